[sv/ccg_pkg.sv]
`timescale 1ns / 1ps

package ccg_pkg;

   localparam int PATCH_WIDTH          = 32;
   localparam int PATCH_HEIGHT         = 32;
   localparam int WEIGHT_FRACTION_BITS = 16;

   localparam int COORD_BITS  = 5;
   localparam int COLOR_BITS  = 24;
   localparam int CHAN_BITS   = 8;
   localparam int CSR_IDX_BITS = 3;

   localparam int X_IDX_BITS = $clog2(PATCH_WIDTH);
   localparam int Y_IDX_BITS = $clog2(PATCH_HEIGHT);

   // register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOP_LEFT     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOP_RIGHT    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOTTOM_RIGHT = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOTTOM_LEFT  = 3'd3;

   typedef logic [CHAN_BITS-1:0]            chan_type;
   typedef logic [WEIGHT_FRACTION_BITS-1:0] weight_type;

   typedef struct packed {
      weight_type wx;
      weight_type wy;
   } weights_type;

   typedef struct packed {
      chan_type top_left;
      chan_type top_right;
      chan_type bottom_right;
      chan_type bottom_left;
   } corners_type;

   // elaboration-time constants for the Q.28 cosine series
   localparam logic [63:0] Q28_ONE   = 64'd1 << 28;
   localparam logic [63:0] THETA_DIV_X = 64'(100 * PATCH_WIDTH);
   localparam logic [63:0] THETA_DIV_Y = 64'(100 * PATCH_HEIGHT);
   localparam int          COS_TERMS = 14;
   localparam logic [63:0] SERIES_DIV [COS_TERMS] = '{
      64'd1,   64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650
   };
   localparam logic [63:0] ROUND_HALF = 64'd1 << (27 - WEIGHT_FRACTION_BITS);
   localparam logic [63:0] W_MAX      = (64'd1 << WEIGHT_FRACTION_BITS) - 64'd1;

   // (1 - cos(3.14 * k / n)) / 2 in Q0.F; used only to build constant tables
   function automatic weight_type cos_weight(input logic [63:0] k, input logic vertical);
      logic        [63:0] theta;
      logic        [63:0] t2;
      logic        [63:0] mag;
      logic signed [63:0] sum;
      logic signed [63:0] w28;
      logic        [63:0] w;
      if (vertical) begin
         theta = (64'd314 * k * Q28_ONE) / THETA_DIV_Y;
      end else begin
         theta = (64'd314 * k * Q28_ONE) / THETA_DIV_X;
      end
      t2  = (theta * theta) >> 28;
      mag = Q28_ONE;
      sum = $signed(Q28_ONE);
      for (int m = 1; m < COS_TERMS; m++) begin
         mag = ((mag * t2) >> 28) / SERIES_DIV[m];
         if (m % 2 == 1) begin
            sum = sum - $signed(mag);
         end else begin
            sum = sum + $signed(mag);
         end
      end
      w28 = ($signed(Q28_ONE) - sum) / 64'sd2;
      if (w28 < 64'sd0) begin
         w28 = 64'sd0;
      end
      if (w28 > $signed(Q28_ONE)) begin
         w28 = $signed(Q28_ONE);
      end
      w = ($unsigned(w28) + ROUND_HALF) >> (28 - WEIGHT_FRACTION_BITS);
      if (w > W_MAX) begin
         w = W_MAX;
      end
      return w[WEIGHT_FRACTION_BITS-1:0];
   endfunction

endpackage

[sv/cosine_corner_gradient_pixel_top.sv]
`timescale 1ns / 1ps

// Cosine-shaded four-corner color patch. Each accepted request (pixel_x, pixel_y)
// returns one response with the pixel's red, green and blue. One request per
// clock is sustained: the five stages (weight lookup, edge products, edge sums,
// vertical product, final sum) all advance together and hold only while a
// finished response waits under rsp_stall. Coordinates past the patch clamp to
// the last row or column. Corner colors are written through the csr port (index
// 0 top left, 1 top right, 2 bottom right, 3 bottom left; red in bits 7:0, green
// 15:8, blue 23:16; other indexes are ignored) and must only change while no
// request is in flight.
module cosine_corner_gradient_pixel_top (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ccg_pkg::COORD_BITS-1:0]       req_pixel_x,
   input  logic [ccg_pkg::COORD_BITS-1:0]       req_pixel_y,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ccg_pkg::CHAN_BITS-1:0]        rsp_red,
   output logic [ccg_pkg::CHAN_BITS-1:0]        rsp_green,
   output logic [ccg_pkg::CHAN_BITS-1:0]        rsp_blue,

   input  logic                                 csr_we,
   input  logic [ccg_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ccg_pkg::COLOR_BITS-1:0]       csr_wdata
);

   localparam int DEPTH = 5;
   localparam int XB = ccg_pkg::X_IDX_BITS;
   localparam int YB = ccg_pkg::Y_IDX_BITS;

   logic [ccg_pkg::COLOR_BITS-1:0] tl_ff, tr_ff, br_ff, bl_ff;
   logic [DEPTH-1:0]               valid_ff, valid_in;
   ccg_pkg::weights_type           weights_ff, weights_in;
   logic                           advance;

   ccg_pkg::weight_type wx_lut [ccg_pkg::PATCH_WIDTH];
   ccg_pkg::weight_type wy_lut [ccg_pkg::PATCH_HEIGHT];

   for (genvar g = 0; g < ccg_pkg::PATCH_WIDTH; g++) begin : g_wx
      localparam ccg_pkg::weight_type W = ccg_pkg::cos_weight(64'(g), 1'b0);
      assign wx_lut[g] = W;
   end
   for (genvar g = 0; g < ccg_pkg::PATCH_HEIGHT; g++) begin : g_wy
      localparam ccg_pkg::weight_type W = ccg_pkg::cos_weight(64'(g), 1'b1);
      assign wy_lut[g] = W;
   end

   logic [31:0]   x_ext, y_ext, x_sat, y_sat;
   logic [XB-1:0] x_idx;
   logic [YB-1:0] y_idx;

   always_comb begin
      x_ext = 32'(req_pixel_x);
      y_ext = 32'(req_pixel_y);
      x_sat = (x_ext >= 32'(ccg_pkg::PATCH_WIDTH))  ? 32'(ccg_pkg::PATCH_WIDTH - 1)  : x_ext;
      y_sat = (y_ext >= 32'(ccg_pkg::PATCH_HEIGHT)) ? 32'(ccg_pkg::PATCH_HEIGHT - 1) : y_ext;
      x_idx = x_sat[XB-1:0];
      y_idx = y_sat[YB-1:0];
      weights_in.wx = wx_lut[x_idx];
      weights_in.wy = wy_lut[y_idx];
   end

   // the whole pipe holds only when a finished response is stalled
   assign advance   = !(valid_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         weights_ff <= weights_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tl_ff <= '0;
         tr_ff <= '0;
         br_ff <= '0;
         bl_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ccg_pkg::CSR_TOP_LEFT:     tl_ff <= csr_wdata;
            ccg_pkg::CSR_TOP_RIGHT:    tr_ff <= csr_wdata;
            ccg_pkg::CSR_BOTTOM_RIGHT: br_ff <= csr_wdata;
            ccg_pkg::CSR_BOTTOM_LEFT:  bl_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ccg_pkg::chan_type chan_res [3];

   for (genvar c = 0; c < 3; c++) begin : g_lane
      ccg_pkg::corners_type corners;
      assign corners.top_left     = tl_ff[c*ccg_pkg::CHAN_BITS +: ccg_pkg::CHAN_BITS];
      assign corners.top_right    = tr_ff[c*ccg_pkg::CHAN_BITS +: ccg_pkg::CHAN_BITS];
      assign corners.bottom_right = br_ff[c*ccg_pkg::CHAN_BITS +: ccg_pkg::CHAN_BITS];
      assign corners.bottom_left  = bl_ff[c*ccg_pkg::CHAN_BITS +: ccg_pkg::CHAN_BITS];

      ccg_lane u_lane (
         .clock    (clock),
         .advance  (advance),
         .corners  (corners),
         .weights  (weights_ff),
         .chan_out (chan_res[c])
      );
   end

   assign rsp_valid = valid_ff[DEPTH-1];
   assign rsp_red   = chan_res[0];
   assign rsp_green = chan_res[1];
   assign rsp_blue  = chan_res[2];

endmodule

[sv/ccg_lane.sv]
`timescale 1ns / 1ps

// One color channel: horizontal mix of both edges, then vertical mix.
// Four register stages; the weights arrive registered from the top level.
module ccg_lane (
   input  logic                 clock,
   input  logic                 advance,
   input  ccg_pkg::corners_type corners,
   input  ccg_pkg::weights_type weights,
   output ccg_pkg::chan_type    chan_out
);

   localparam int F = ccg_pkg::WEIGHT_FRACTION_BITS;
   localparam int PROD_BITS = ccg_pkg::CHAN_BITS + F;

   // stage 2: edge products
   ccg_pkg::chan_type   top_a_ff, top_a_in, bot_a_ff, bot_a_in;
   ccg_pkg::chan_type   top_mag_ff, top_mag_in, bot_mag_ff, bot_mag_in;
   logic                top_neg_ff, top_neg_in, bot_neg_ff, bot_neg_in;
   ccg_pkg::weight_type wy2_ff;
   // stage 3: edge values
   ccg_pkg::chan_type   top_ff, top_in, bot_ff, bot_in;
   ccg_pkg::weight_type wy3_ff;
   // stage 4: vertical product
   ccg_pkg::chan_type   v_a_ff, v_mag_ff, v_mag_in;
   logic                v_neg_ff, v_neg_in;
   // stage 5: result
   ccg_pkg::chan_type   res_ff, res_in;

   logic [PROD_BITS-1:0] top_prod, bot_prod, v_prod;
   ccg_pkg::chan_type    top_diff, bot_diff, v_diff;

   always_comb begin
      top_a_in   = corners.top_left;
      top_neg_in = corners.top_right < corners.top_left;
      top_diff   = top_neg_in ? corners.top_left - corners.top_right
                              : corners.top_right - corners.top_left;
      top_prod   = PROD_BITS'(top_diff) * PROD_BITS'(weights.wx);
      top_mag_in = top_prod[PROD_BITS-1:F];

      bot_a_in   = corners.bottom_left;
      bot_neg_in = corners.bottom_right < corners.bottom_left;
      bot_diff   = bot_neg_in ? corners.bottom_left - corners.bottom_right
                              : corners.bottom_right - corners.bottom_left;
      bot_prod   = PROD_BITS'(bot_diff) * PROD_BITS'(weights.wx);
      bot_mag_in = bot_prod[PROD_BITS-1:F];
   end

   always_comb begin
      top_in = top_neg_ff ? top_a_ff - top_mag_ff : top_a_ff + top_mag_ff;
      bot_in = bot_neg_ff ? bot_a_ff - bot_mag_ff : bot_a_ff + bot_mag_ff;
   end

   always_comb begin
      v_neg_in = bot_ff < top_ff;
      v_diff   = v_neg_in ? top_ff - bot_ff : bot_ff - top_ff;
      v_prod   = PROD_BITS'(v_diff) * PROD_BITS'(wy3_ff);
      v_mag_in = v_prod[PROD_BITS-1:F];
   end

   always_comb begin
      res_in = v_neg_ff ? v_a_ff - v_mag_ff : v_a_ff + v_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         top_a_ff   <= top_a_in;
         top_neg_ff <= top_neg_in;
         top_mag_ff <= top_mag_in;
         bot_a_ff   <= bot_a_in;
         bot_neg_ff <= bot_neg_in;
         bot_mag_ff <= bot_mag_in;
         wy2_ff     <= weights.wy;

         top_ff     <= top_in;
         bot_ff     <= bot_in;
         wy3_ff     <= wy2_ff;

         v_a_ff     <= top_ff;
         v_neg_ff   <= v_neg_in;
         v_mag_ff   <= v_mag_in;

         res_ff     <= res_in;
      end
   end

   assign chan_out = res_ff;

endmodule

[verif/cosine_corner_gradient_pixel_top_tb.sv]
`timescale 1ns / 1ps

module cosine_corner_gradient_pixel_top_tb;

   localparam int PIPE_DEPTH    = 8;
   localparam int QUIET_LIMIT   = 4000;
   localparam int RANDOM_PHASES = 20;
   localparam int SERIES_TERMS  = 14;
   localparam int Q28_SHIFT     = 28;

   localparam logic [ccg_pkg::CSR_IDX_BITS-1:0] CSR_FIRST_UNUSED =
      ccg_pkg::CSR_BOTTOM_LEFT + 1'b1;
   localparam logic [ccg_pkg::CSR_IDX_BITS-1:0] CSR_LAST_UNUSED  = '1;

   typedef struct packed {
      ccg_pkg::chan_type blue;
      ccg_pkg::chan_type green;
      ccg_pkg::chan_type red;
   } rgb_type;

   typedef enum logic {STEP_CSR, STEP_PIXEL} step_kind_type;

   // value is the write data for a csr row, the expected color for a known pixel row
   typedef struct packed {
      step_kind_type                       kind;
      logic [ccg_pkg::CSR_IDX_BITS-1:0]    index;
      logic [ccg_pkg::COLOR_BITS-1:0]      value;
      logic [ccg_pkg::COORD_BITS-1:0]      x;
      logic [ccg_pkg::COORD_BITS-1:0]      y;
      logic                                known;
   } setup_row_type;

   localparam setup_row_type DIRECTED_ROWS [25] = '{
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd0,  5'd0,  1'b1},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd31, 5'd31, 1'b1},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd17, 5'd5,  1'b1},
      '{STEP_CSR,   ccg_pkg::CSR_TOP_LEFT,     24'h0080FF, 5'd0,  5'd0,  1'b0},
      '{STEP_CSR,   ccg_pkg::CSR_TOP_RIGHT,    24'hFF0000, 5'd0,  5'd0,  1'b0},
      '{STEP_CSR,   ccg_pkg::CSR_BOTTOM_RIGHT, 24'h55FF01, 5'd0,  5'd0,  1'b0},
      '{STEP_CSR,   ccg_pkg::CSR_BOTTOM_LEFT,  24'hAA3CFE, 5'd0,  5'd0,  1'b0},
      // unused indexes must not disturb the corners
      '{STEP_CSR,   CSR_FIRST_UNUSED,          24'hFFFFFF, 5'd0,  5'd0,  1'b0},
      '{STEP_CSR,   CSR_LAST_UNUSED,           24'h123456, 5'd0,  5'd0,  1'b0},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h0080FF, 5'd0,  5'd0,  1'b1},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd31, 5'd0,  1'b0},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd0,  5'd31, 1'b0},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd31, 5'd31, 1'b0},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd16, 5'd16, 1'b0},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd1,  5'd30, 1'b0},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd30, 5'd1,  1'b0},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd21, 5'd10, 1'b0},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'h000000, 5'd10, 5'd21, 1'b0},
      // flat patch: every pixel is the corner color
      '{STEP_CSR,   ccg_pkg::CSR_TOP_LEFT,     24'hC35AA5, 5'd0,  5'd0,  1'b0},
      '{STEP_CSR,   ccg_pkg::CSR_TOP_RIGHT,    24'hC35AA5, 5'd0,  5'd0,  1'b0},
      '{STEP_CSR,   ccg_pkg::CSR_BOTTOM_RIGHT, 24'hC35AA5, 5'd0,  5'd0,  1'b0},
      '{STEP_CSR,   ccg_pkg::CSR_BOTTOM_LEFT,  24'hC35AA5, 5'd0,  5'd0,  1'b0},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'hC35AA5, 5'd0,  5'd31, 1'b1},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'hC35AA5, 5'd31, 5'd31, 1'b1},
      '{STEP_PIXEL, ccg_pkg::CSR_TOP_LEFT,     24'hC35AA5, 5'd9,  5'd22, 1'b1}
   };

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [ccg_pkg::COORD_BITS-1:0]   req_pixel_x;
   logic [ccg_pkg::COORD_BITS-1:0]   req_pixel_y;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [ccg_pkg::CHAN_BITS-1:0]    rsp_red;
   logic [ccg_pkg::CHAN_BITS-1:0]    rsp_green;
   logic [ccg_pkg::CHAN_BITS-1:0]    rsp_blue;
   logic                             csr_we;
   logic [ccg_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [ccg_pkg::COLOR_BITS-1:0]   csr_wdata;

   ccg_pkg::weight_type            col_weight [ccg_pkg::PATCH_WIDTH];
   ccg_pkg::weight_type            row_weight [ccg_pkg::PATCH_HEIGHT];
   logic [ccg_pkg::COLOR_BITS-1:0] corner_shadow [4];
   rgb_type                        pending_colors [$];
   int                             error_count;
   int                             send_idle_pct;
   int                             recv_stall_pct;
   int                             quiet_cycles;

   cosine_corner_gradient_pixel_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // (1 - cos(3.14 k / n)) / 2 via a truncated Taylor series in Q.28
   function automatic ccg_pkg::weight_type shade_weight(input int k, input int n);
      longint unsigned angle;
      longint unsigned angle_sq;
      longint unsigned term;
      longint unsigned rounded;
      longint          series;
      longint          half;
      angle    = ((64'd314 * k) << Q28_SHIFT) / (64'd100 * n);
      angle_sq = (angle * angle) >> Q28_SHIFT;
      term     = 64'd1 << Q28_SHIFT;
      series   = longint'(term);
      for (int m = 1; m < SERIES_TERMS; m++) begin
         term = ((term * angle_sq) >> Q28_SHIFT) / longint'((2 * m - 1) * (2 * m));
         if (m % 2 == 1) begin
            series = series - longint'(term);
         end else begin
            series = series + longint'(term);
         end
      end
      half = ((longint'(1) <<< Q28_SHIFT) - series) / 2;
      if (half < 0) begin
         half = 0;
      end
      if (half > (longint'(1) <<< Q28_SHIFT)) begin
         half = longint'(1) <<< Q28_SHIFT;
      end
      rounded = (longint'(half) + (64'd1 << (27 - ccg_pkg::WEIGHT_FRACTION_BITS)))
                >> (Q28_SHIFT - ccg_pkg::WEIGHT_FRACTION_BITS);
      if (rounded > (64'd1 << ccg_pkg::WEIGHT_FRACTION_BITS) - 1) begin
         rounded = (64'd1 << ccg_pkg::WEIGHT_FRACTION_BITS) - 1;
      end
      return ccg_pkg::weight_type'(rounded);
   endfunction

   // a + trunc((b - a) * w), wrapping at 8 bits
   function automatic ccg_pkg::chan_type blend_channel(input ccg_pkg::chan_type a,
                                                       input ccg_pkg::chan_type b,
                                                       input ccg_pkg::weight_type w);
      longint unsigned step;
      if (b >= a) begin
         step = (longint'(b - a) * w) >> ccg_pkg::WEIGHT_FRACTION_BITS;
         return ccg_pkg::chan_type'(a + step);
      end
      step = (longint'(a - b) * w) >> ccg_pkg::WEIGHT_FRACTION_BITS;
      return ccg_pkg::chan_type'(a - step);
   endfunction

   function automatic rgb_type shade_pixel(input logic [ccg_pkg::COORD_BITS-1:0] x,
                                           input logic [ccg_pkg::COORD_BITS-1:0] y);
      int                             col;
      int                             row;
      ccg_pkg::chan_type              top;
      ccg_pkg::chan_type              bottom;
      logic [ccg_pkg::COLOR_BITS-1:0] packed_rgb;
      col = (x >= ccg_pkg::PATCH_WIDTH) ? ccg_pkg::PATCH_WIDTH - 1 : int'(x);
      row = (y >= ccg_pkg::PATCH_HEIGHT) ? ccg_pkg::PATCH_HEIGHT - 1 : int'(y);
      for (int ch = 0; ch < 3; ch++) begin
         top    = blend_channel(corner_shadow[ccg_pkg::CSR_TOP_LEFT][8*ch +: 8],
                                corner_shadow[ccg_pkg::CSR_TOP_RIGHT][8*ch +: 8],
                                col_weight[col]);
         bottom = blend_channel(corner_shadow[ccg_pkg::CSR_BOTTOM_LEFT][8*ch +: 8],
                                corner_shadow[ccg_pkg::CSR_BOTTOM_RIGHT][8*ch +: 8],
                                col_weight[col]);
         packed_rgb[8*ch +: 8] = blend_channel(top, bottom, row_weight[row]);
      end
      return rgb_type'(packed_rgb);
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      $display("%0t ERROR: %s", $time, msg);
   endtask

   // entered and left at a falling edge
   task automatic send_pixel(input logic [ccg_pkg::COORD_BITS-1:0] x,
                             input logic [ccg_pkg::COORD_BITS-1:0] y, input rgb_type color);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      do @(posedge clock); while (req_stall);
      pending_colors.insert(pending_colors.size(), color);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH) @(negedge clock);
   endtask

   task automatic csr_put(input logic [ccg_pkg::CSR_IDX_BITS-1:0] idx,
                          input logic [ccg_pkg::COLOR_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx <= ccg_pkg::CSR_BOTTOM_LEFT) begin
         corner_shadow[idx] = data;
      end
      @(negedge clock);
   endtask

   task automatic program_corners(input logic [ccg_pkg::COLOR_BITS-1:0] tl,
                                  input logic [ccg_pkg::COLOR_BITS-1:0] tr,
                                  input logic [ccg_pkg::COLOR_BITS-1:0] br,
                                  input logic [ccg_pkg::COLOR_BITS-1:0] bl);
      drain_pipeline();
      csr_put(ccg_pkg::CSR_TOP_LEFT, tl);
      csr_put(ccg_pkg::CSR_TOP_RIGHT, tr);
      csr_put(ccg_pkg::CSR_BOTTOM_RIGHT, br);
      csr_put(ccg_pkg::CSR_BOTTOM_LEFT, bl);
      csr_put(CSR_FIRST_UNUSED + ccg_pkg::CSR_IDX_BITS'($urandom_range(3)),
              ccg_pkg::COLOR_BITS'($urandom()));
      csr_we <= 1'b0;
   endtask

   function automatic logic [ccg_pkg::COORD_BITS-1:0] pick_coord();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return ccg_pkg::COORD_BITS'($urandom_range(31));
      endcase
   endfunction

   // response check
   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            report_error($sformatf("response %02x/%02x/%02x with no request pending",
                                   rsp_red, rsp_green, rsp_blue));
         end else begin
            want = pending_colors.pop_front();
            if (rsp_red !== want.red)
               report_error($sformatf("red %02x, want %02x", rsp_red, want.red));
            if (rsp_green !== want.green)
               report_error($sformatf("green %02x, want %02x", rsp_green, want.green));
            if (rsp_blue !== want.blue)
               report_error($sformatf("blue %02x, want %02x", rsp_blue, want.blue));
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("cosine_corner_gradient_pixel_top_tb: done, errors");
      $finish;
   end

   initial begin
      setup_row_type                  row;
      bit                             csr_open;
      int                             burst;
      logic [ccg_pkg::COORD_BITS-1:0] px;
      logic [ccg_pkg::COORD_BITS-1:0] py;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel_x    = '0;
      req_pixel_y    = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      csr_open       = 1'b0;
      foreach (corner_shadow[i]) corner_shadow[i] = '0;
      foreach (col_weight[k]) col_weight[k] = shade_weight(k, ccg_pkg::PATCH_WIDTH);
      foreach (row_weight[k]) row_weight[k] = shade_weight(k, ccg_pkg::PATCH_HEIGHT);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == STEP_CSR) begin
            if (!csr_open) drain_pipeline();
            csr_put(row.index, row.value);
            csr_open = 1'b1;
         end else begin
            if (csr_open) csr_we <= 1'b0;
            csr_open = 1'b0;
            send_pixel(row.x, row.y,
                       row.known ? rgb_type'(row.value) : shade_pixel(row.x, row.y));
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         case (phase)
            0: program_corners('0, '0, '0, '0);
            1: program_corners('1, '1, '1, '1);
            2: program_corners('0, '1, '0, '1);
            3: program_corners('1, '0, '1, '0);
            default: program_corners(ccg_pkg::COLOR_BITS'($urandom()),
                                     ccg_pkg::COLOR_BITS'($urandom()),
                                     ccg_pkg::COLOR_BITS'($urandom()),
                                     ccg_pkg::COLOR_BITS'($urandom()));
         endcase
         burst = $urandom_range(70, 115);
         repeat (burst) begin
            px = pick_coord();
            py = pick_coord();
            send_pixel(px, py, shade_pixel(px, py));
         end
      end

      drain_pipeline();
      if (pending_colors.size() != 0)
         report_error($sformatf("%0d responses never arrived", pending_colors.size()));
      if (error_count == 0) begin
         $display("cosine_corner_gradient_pixel_top_tb: done, clean");
      end else begin
         $display("cosine_corner_gradient_pixel_top_tb: done, errors");
      end
      $finish;
   end

endmodule
